/* hw/rtl/pftfh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftfh_pkg
// Shared types and constants for the five-tuple parser and flow hash.
// ----------------------------------------------------------------------------
package pftfh_pkg;

  localparam logic [15:0] ETH_VLAN_C  = 16'h8100;
  localparam logic [15:0] ETH_VLAN_S  = 16'h88A8;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] ETH_IPV6    = 16'h86DD;
  localparam logic [4:0]  ETH_HDR_LEN = 5'd14;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;

  localparam logic [1:0] ST_PARSED = 2'd0;
  localparam logic [1:0] ST_NOT_IP = 2'd1;
  localparam logic [1:0] ST_BAD_IHL = 2'd2;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  ip_ver;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
    logic [11:0] flow_index;
    logic [4:0]  l3_offset;
    logic [15:0] l3_length;
  } out_item_t;

  // Parse state handed to the result stage on the last byte.
  typedef struct packed {
    logic [15:0] caplen;
    logic [15:0] ethertype;
    logic [4:0]  offset;
    logic [3:0]  header_words;
    logic [7:0]  proto;
    logic [63:0] src0;
    logic [63:0] src1;
    logic [63:0] dst0;
    logic [63:0] dst1;
    logic [15:0] port0;
    logic [15:0] port1;
  } frame_t;

  // Byte order reversal of a 64-bit word.
  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  // Byte order reversal of a 32-bit word.
  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* hw/rtl/pftfh_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/pftfh_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftfh_parse
// Byte-by-byte header parser; captures the five-tuple fields of one frame.
// ----------------------------------------------------------------------------
module pftfh_parse #(
  parameter int MAX_VLAN_TAGS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  pftfh_pkg::in_item_t item,
  output pftfh_pkg::frame_t  frame
);
  import pftfh_pkg::*;

  logic [15:0] byte_position;
  logic [15:0] current_ethertype;
  logic [4:0]  header_offset;
  logic [1:0]  vlan_count;
  logic [3:0]  header_words;
  logic [7:0]  proto_byte;
  logic [63:0] src0, src1, dst0, dst1;
  logic [15:0] port0, port1;

  frame_t nx;
  logic [16:0] p17, r17, hl17;
  logic [15:0] r;
  logic [7:0]  b;
  logic        tag_end, vlan_take, in_l3;

  // Next parse state after the current byte.
  always_comb begin
    b    = item.data_byte;
    p17  = {1'b0, byte_position};
    nx.caplen       = (byte_position == 16'hFFFF) ? byte_position : byte_position + 16'd1;
    nx.ethertype    = current_ethertype;
    nx.offset       = header_offset;
    nx.header_words = header_words;
    nx.proto        = proto_byte;
    nx.src0 = src0; nx.src1 = src1; nx.dst0 = dst0; nx.dst1 = dst1;
    nx.port0 = port0; nx.port1 = port1;
    tag_end = (p17 + 17'd1 == {12'd0, header_offset});
    if ((p17 + 17'd2 == {12'd0, header_offset}) || tag_end) begin
      nx.ethertype = {current_ethertype[7:0], b};
    end
    vlan_take = tag_end && (nx.ethertype == ETH_VLAN_C || nx.ethertype == ETH_VLAN_S)
                && ({30'd0, vlan_count} < MAX_VLAN_TAGS);
    in_l3 = !vlan_take && (p17 >= {12'd0, header_offset});
    r17  = p17 - {12'd0, header_offset};
    r    = r17[15:0];
    hl17 = {11'd0, header_words, 2'b00};
    if (in_l3 && current_ethertype == ETH_IPV4) begin
      if (r == 16'd0) nx.header_words = b[3:0];
      else if (r == 16'd9) nx.proto = b;
      else if (r >= 16'd12 && r < 16'd16) nx.src1 = {src1[55:0], b};
      else if (r >= 16'd16 && r < 16'd20) nx.dst1 = {dst1[55:0], b};
      if (r17 >= hl17 && r17 < hl17 + 17'd4 && hl17 >= 17'd20) begin
        if (((r17 - hl17) & 17'd2) == 17'd0) nx.port0 = {port0[7:0], b};
        else nx.port1 = {port1[7:0], b};
      end
    end else if (in_l3 && current_ethertype == ETH_IPV6) begin
      if (r == 16'd6) nx.proto = b;
      else if (r >= 16'd8 && r < 16'd16) nx.src0 = {src0[55:0], b};
      else if (r >= 16'd16 && r < 16'd24) nx.src1 = {src1[55:0], b};
      else if (r >= 16'd24 && r < 16'd32) nx.dst0 = {dst0[55:0], b};
      else if (r >= 16'd32 && r < 16'd40) nx.dst1 = {dst1[55:0], b};
      else if (r >= 16'd40 && r < 16'd42) nx.port0 = {port0[7:0], b};
      else if (r >= 16'd42 && r < 16'd44) nx.port1 = {port1[7:0], b};
    end
  end

  assign frame = nx;

  // Parse registers; cleared at reset and after each last byte.
  always_ff @(posedge clk) begin
    if (rst || (take && item.last_byte)) begin
      byte_position <= '0; current_ethertype <= '0; header_offset <= ETH_HDR_LEN;
      vlan_count <= '0; header_words <= '0; proto_byte <= '0;
      src0 <= '0; src1 <= '0; dst0 <= '0; dst1 <= '0; port0 <= '0; port1 <= '0;
    end else if (take) begin
      byte_position <= nx.caplen; current_ethertype <= nx.ethertype;
      header_offset <= vlan_take ? header_offset + 5'd4 : header_offset;
      vlan_count <= vlan_take ? vlan_count + 2'd1 : vlan_count;
      header_words <= nx.header_words; proto_byte <= nx.proto;
      src0 <= nx.src0; src1 <= nx.src1; dst0 <= nx.dst0; dst1 <= nx.dst1;
      port0 <= nx.port0; port1 <= nx.port1;
    end
  end
endmodule

/* hw/rtl/pftfh_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftfh_result
// Checks a finished frame, folds the hash and forms the result item.
// ----------------------------------------------------------------------------
module pftfh_result #(
  parameter int BUCKET_COUNT = 4096
) (
  input  pftfh_pkg::frame_t    frame,
  output pftfh_pkg::out_item_t res
);
  import pftfh_pkg::*;

  localparam logic [31:0] MASK = 32'(BUCKET_COUNT - 1);

  logic [16:0] cap, off, hl, tail;
  logic        v4, v6, bad, ports_ok;
  logic [15:0] sp, dp;
  logic [63:0] h;
  logic [31:0] h32;

  // Frame checks, port qualification and hash fold.
  always_comb begin
    cap  = {1'b0, frame.caplen};
    off  = {12'd0, frame.offset};
    hl   = {11'd0, frame.header_words, 2'b00};
    v4   = (frame.ethertype == ETH_IPV4) && (cap >= off + 17'd20);
    bad  = v4 && (frame.header_words < 4'd5 || cap < off + hl);
    v6   = (frame.ethertype == ETH_IPV6) && (cap >= off + 17'd40);
    tail = v4 ? off + hl : off + 17'd40;
    ports_ok = (frame.proto == PROTO_TCP && cap >= tail + 17'd20) ||
               (frame.proto == PROTO_UDP && cap >= tail + 17'd8);
    sp = ports_ok ? frame.port0 : 16'd0;
    dp = ports_ok ? frame.port1 : 16'd0;
    if (v4) begin
      h = {32'd0, swap32(frame.src1[31:0])} + {32'd0, swap32(frame.dst1[31:0])};
    end else begin
      h = swap64(frame.src0) ^ swap64(frame.src1) ^ swap64(frame.dst0) ^ swap64(frame.dst1);
    end
    h   = h + {32'd0, sp, dp} + {56'd0, frame.proto};
    h32 = h[31:0] ^ h[63:32];

    res = '0;
    if (bad) begin
      res.status = ST_BAD_IHL;
    end else if (!v4 && !v6) begin
      res.status = ST_NOT_IP;
    end else begin
      res.status      = ST_PARSED;
      res.ip_ver      = v4 ? 3'd4 : 3'd6;
      res.src_addr_hi = v4 ? 64'd0 : frame.src0;
      res.src_addr_lo = frame.src1;
      res.dst_addr_hi = v4 ? 64'd0 : frame.dst0;
      res.dst_addr_lo = frame.dst1;
      res.source_port = sp;
      res.dest_port   = dp;
      res.protocol    = frame.proto;
      res.flow_index  = 12'(h32 & MASK);
      res.l3_offset   = frame.offset;
      res.l3_length   = frame.caplen - {11'd0, frame.offset};
    end
  end
endmodule

/* hw/rtl/packet_five_tuple_flow_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_five_tuple_flow_hash
// Ethernet/IP five-tuple parser with a flow bucket hash.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one frame byte per item, from the destination MAC onwards,
//   with last_byte set on the final captured byte. out_ch carries one result
//   item per frame: status, addresses, ports, protocol, bucket index and the
//   L3 offset and length.
//   Throughput is one byte item per cycle while in_ch is ready. The result of
//   a frame appears on out_ch in the cycle after its last byte is accepted,
//   held in an output register; the parse state is one set of registers
//   updated per byte. When the receiver stalls, the held result waits and
//   in_ch stays ready until another last byte arrives, which then waits until
//   the result is taken. Reset clears the parse state and empties the output
//   register. Bytes past 65535 are still accepted but the length saturates.
// ----------------------------------------------------------------------------
module packet_five_tuple_flow_hash #(
  parameter int BUCKET_COUNT  = 4096,
  parameter int MAX_VLAN_TAGS = 2
) (
  input logic clk,
  input logic rst,
  stream_if.sink   in_ch,
  stream_if.source out_ch
);
  import pftfh_pkg::*;

  in_item_t  item;
  frame_t    frame;
  out_item_t res;
  out_item_t res_reg;
  logic      res_valid;
  logic      take;

  assign item = in_ch.data;
  assign in_ch.ready = !(item.last_byte && res_valid && !out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;

  pftfh_parse #(.MAX_VLAN_TAGS(MAX_VLAN_TAGS)) u_parse (
    .clk(clk), .rst(rst), .take(take), .item(item), .frame(frame)
  );

  pftfh_result #(.BUCKET_COUNT(BUCKET_COUNT)) u_result (
    .frame(frame), .res(res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && item.last_byte) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
    if (take && item.last_byte) begin
      res_reg <= res;
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.data  = res_reg;
endmodule
